FILE: hdl/prws_pkg.sv
// ----------------------------------------------------------------------------
// prws_pkg: shared definitions for the probe RTT window statistics core
// Widths, status codes, fixed constants and the divider status struct.
// ----------------------------------------------------------------------------
package prws_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int AVG_CAP    = 12;

  localparam int RTT_W  = 32;
  localparam int SEQ_W  = 32;
  localparam int WAVG_W = 40;                        // 32.8 fixed point
  localparam int FRAC_W = 8;
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);   // holds 0 .. HIST_DEPTH
  localparam int AVG_W  = $clog2(AVG_CAP + 1);      // holds 0 .. AVG_CAP
  localparam int SUM_W  = RTT_W + CNT_W;
  localparam int LOSS_W = 14;
  localparam int TOP_IDX = HIST_DEPTH - 1;

  // The running average numerator is the widest dividend the divider sees.
  localparam int DVD_W = WAVG_W + AVG_W + 1;
  localparam int DVS_W = (AVG_W > CNT_W) ? AVG_W : CNT_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [RTT_W-1:0]  RTT_FLOOR_US = RTT_W'(1000);
  localparam logic [LOSS_W-1:0] LOSS_SCALE   = LOSS_W'(10000);

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_LOST     = 2'd1;
  localparam logic [1:0] ST_ANSWERED = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/ping_rtt_window_statistics_core.sv
// ----------------------------------------------------------------------------
// ping_rtt_window_statistics_core: probe RTT window statistics
// Keeps a sliding window of probe slots keyed by sequence number, a running
// RTT average, and reports window minimum, maximum, mean and loss per reply.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_ready  | op, seq, sent_time_us,
//          |           |                    | rcvd_time_us
//  out     | output    | out_valid/out_ready| weighted_avg_rtt_us, mean_rtt_us,
//          |           |                    | min_rtt_us, max_rtt_us,
//          |           |                    | loss_hundredths
//
// A sent event moves the window by d slots, d being 0 .. HIST_DEPTH.
// A reply takes the window move, three runs of the serial divider and a
// one-slot-per-cycle scan of the window, which rotates once round.
// The window moves one slot per cycle. Reset clears the window status,
// counters and average at once.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block holds its final step until the result is taken.
module ping_rtt_window_statistics_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [31:0]                   seq,
  input  logic [31:0]                   sent_time_us,
  input  logic [31:0]                   rcvd_time_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   weighted_avg_rtt_us,
  output logic [31:0]                   mean_rtt_us,
  output logic [31:0]                   min_rtt_us,
  output logic [31:0]                   max_rtt_us,
  output logic [13:0]                   loss_hundredths
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PREP      = 4'd1;
  localparam logic [3:0] S_SHIFT     = 4'd2;
  localparam logic [3:0] S_WRITE     = 4'd3;
  localparam logic [3:0] S_AVG_GO    = 4'd4;
  localparam logic [3:0] S_AVG_WAIT  = 4'd5;
  localparam logic [3:0] S_SCAN      = 4'd6;
  localparam logic [3:0] S_MEAN_SET  = 4'd7;
  localparam logic [3:0] S_MEAN_GO   = 4'd8;
  localparam logic [3:0] S_MEAN_WAIT = 4'd9;
  localparam logic [3:0] S_LOSS_GO   = 4'd10;
  localparam logic [3:0] S_LOSS_WAIT = 4'd11;
  localparam logic [3:0] S_FIN       = 4'd12;

  logic [3:0] state;

  // Latched item.
  logic                          op_r;
  logic [prws_pkg::SEQ_W-1:0]    seq_r;
  logic [prws_pkg::RTT_W-1:0]    sent_r;
  logic [prws_pkg::RTT_W-1:0]    rcvd_r;

  // Block state.
  logic [1:0]                    status   [prws_pkg::HIST_DEPTH];
  logic [prws_pkg::RTT_W-1:0]    rtt_hist [prws_pkg::HIST_DEPTH];
  logic [prws_pkg::SEQ_W-1:0]    highest_seq;
  logic [prws_pkg::SEQ_W-1:0]    sent_count;
  logic [prws_pkg::AVG_W-1:0]    avg_div;
  logic [prws_pkg::WAVG_W-1:0]   wavg;

  // Working registers.
  logic [prws_pkg::RTT_W-1:0]    rtt;
  logic [prws_pkg::CNT_W-1:0]    cnt;
  logic [prws_pkg::CNT_W-1:0]    occupied;
  logic [prws_pkg::CNT_W-1:0]    lost;
  logic [prws_pkg::CNT_W-1:0]    answered;
  logic [prws_pkg::SUM_W-1:0]    sum;
  logic [prws_pkg::RTT_W-1:0]    mn;
  logic [prws_pkg::RTT_W-1:0]    mx;
  logic [prws_pkg::RTT_W-1:0]    mean_q;
  logic [prws_pkg::LOSS_W-1:0]   loss_q;

  // Divider interface.
  logic                          div_start;
  logic [prws_pkg::DVD_W-1:0]    div_a;
  logic [prws_pkg::DVS_W-1:0]    div_b;
  prws_pkg::div_stat_t           div_st;
  logic [prws_pkg::DVD_W-1:0]    div_q;

  // Combinational helpers.
  logic [prws_pkg::SEQ_W-1:0]    new_top;
  logic                          do_move;
  logic [prws_pkg::SEQ_W-1:0]    move_dist;
  logic [prws_pkg::CNT_W-1:0]    shift_n;
  logic [prws_pkg::RTT_W-1:0]    rtt_diff;
  logic [prws_pkg::AVG_W-1:0]    avg_div_next;
  logic [prws_pkg::AVG_W-1:0]    n_minus_1;
  logic [prws_pkg::WAVG_W+prws_pkg::AVG_W-1:0] avg_prod;
  logic [prws_pkg::CNT_W+prws_pkg::LOSS_W-1:0] loss_prod;
  logic                          shift_step;
  logic                          scan_step;
  logic                          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign new_top   = op_r ? seq_r : sent_count;
  assign do_move   = new_top > highest_seq;
  assign move_dist = new_top - highest_seq;
  assign shift_n   = (move_dist >= prws_pkg::SEQ_W'(prws_pkg::HIST_DEPTH)) ?
                     prws_pkg::CNT_W'(prws_pkg::HIST_DEPTH) :
                     move_dist[prws_pkg::CNT_W-1:0];
  assign rtt_diff = rcvd_r - sent_r;
  assign avg_div_next = (avg_div < prws_pkg::AVG_W'(prws_pkg::AVG_CAP)) ?
                        avg_div + 1'b1 : avg_div;
  assign n_minus_1 = avg_div - 1'b1;
  assign avg_prod  = wavg * n_minus_1;
  assign loss_prod = lost * prws_pkg::LOSS_SCALE;

  assign shift_step = (state == S_SHIFT);
  assign scan_step  = (state == S_SCAN);
  assign div_start  = (state == S_AVG_GO) || (state == S_MEAN_GO) ||
                      (state == S_LOSS_GO);

  prws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_st),
    .quotient (div_q)
  );

  // Window status: a move shifts towards slot 0 and brings in lost slots at
  // the top; the scan rotates the window once round so it ends unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < prws_pkg::HIST_DEPTH; j++) begin
        status[j] <= prws_pkg::ST_EMPTY;
      end
    end else if (shift_step || scan_step) begin
      for (int j = 0; j < prws_pkg::TOP_IDX; j++) begin
        status[j] <= status[j+1];
      end
      status[prws_pkg::TOP_IDX] <= shift_step ? prws_pkg::ST_LOST : status[0];
    end else if (state == S_WRITE) begin
      status[prws_pkg::TOP_IDX] <= prws_pkg::ST_ANSWERED;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_step || scan_step) begin
      for (int j = 0; j < prws_pkg::TOP_IDX; j++) begin
        rtt_hist[j] <= rtt_hist[j+1];
      end
      rtt_hist[prws_pkg::TOP_IDX] <= rtt_hist[0];
    end else if (state == S_WRITE) begin
      rtt_hist[prws_pkg::TOP_IDX] <= rtt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      highest_seq <= '0;
      sent_count  <= '0;
      avg_div     <= '0;
      wavg        <= '0;
      out_valid   <= 1'b0;
    end else begin
      // In the final step a taken result is replaced by the new one below.
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op;
            seq_r  <= seq;
            sent_r <= sent_time_us;
            rcvd_r <= rcvd_time_us;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          if (do_move) begin
            highest_seq <= new_top;
            cnt         <= shift_n;
          end
          if (!op_r) begin
            sent_count <= sent_count + 1'b1;
            state      <= do_move ? S_SHIFT : S_IDLE;
          end else begin
            rtt     <= (rtt_diff < prws_pkg::RTT_FLOOR_US) ? prws_pkg::RTT_FLOOR_US
                                                           : rtt_diff;
            avg_div <= avg_div_next;
            state   <= do_move ? S_SHIFT : S_WRITE;
          end
        end
        S_SHIFT: begin
          cnt <= cnt - 1'b1;
          if (cnt == prws_pkg::CNT_W'(1)) begin
            state <= op_r ? S_WRITE : S_IDLE;
          end
        end
        S_WRITE: begin
          div_a <= prws_pkg::DVD_W'(avg_prod) +
                   prws_pkg::DVD_W'({rtt, {prws_pkg::FRAC_W{1'b0}}});
          div_b <= prws_pkg::DVS_W'(avg_div);
          state <= S_AVG_GO;
        end
        S_AVG_GO: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_st.done) begin
            wavg     <= div_q[prws_pkg::WAVG_W-1:0];
            cnt      <= prws_pkg::CNT_W'(prws_pkg::HIST_DEPTH);
            occupied <= '0;
            lost     <= '0;
            answered <= '0;
            sum      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status[0] != prws_pkg::ST_EMPTY) begin
            occupied <= occupied + 1'b1;
            if (status[0] != prws_pkg::ST_ANSWERED) begin
              lost <= lost + 1'b1;
            end else begin
              answered <= answered + 1'b1;
              sum      <= sum + prws_pkg::SUM_W'(rtt_hist[0]);
              if (answered == '0 || rtt_hist[0] < mn) begin
                mn <= rtt_hist[0];
              end
              if (answered == '0 || rtt_hist[0] > mx) begin
                mx <= rtt_hist[0];
              end
            end
          end
          cnt <= cnt - 1'b1;
          if (cnt == prws_pkg::CNT_W'(1)) begin
            state <= S_MEAN_SET;
          end
        end
        S_MEAN_SET: begin
          div_a <= prws_pkg::DVD_W'(sum);
          div_b <= prws_pkg::DVS_W'(answered);
          state <= S_MEAN_GO;
        end
        S_MEAN_GO: begin
          state <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_st.done) begin
            mean_q <= div_q[prws_pkg::RTT_W-1:0];
            div_a  <= prws_pkg::DVD_W'(loss_prod);
            div_b  <= prws_pkg::DVS_W'(occupied);
            state  <= S_LOSS_GO;
          end
        end
        S_LOSS_GO: begin
          state <= S_LOSS_WAIT;
        end
        S_LOSS_WAIT: begin
          if (div_st.done) begin
            loss_q <= div_q[prws_pkg::LOSS_W-1:0];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            weighted_avg_rtt_us <= wavg[prws_pkg::WAVG_W-1:prws_pkg::FRAC_W];
            mean_rtt_us         <= mean_q;
            min_rtt_us          <= mn;
            max_rtt_us          <= mx;
            loss_hundredths     <= loss_q;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_top_answered: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> status[prws_pkg::TOP_IDX] == prws_pkg::ST_ANSWERED)
    else $error("newest slot not answered after a reply");

  a_divisor_cap: assert property (@(posedge clk) disable iff (rst)
    avg_div <= prws_pkg::AVG_W'(prws_pkg::AVG_CAP))
    else $error("average divisor above its cap");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_rtt_us <= max_rtt_us)
    else $error("window minimum above maximum");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> loss_hundredths <= prws_pkg::LOSS_SCALE)
    else $error("loss ratio out of range");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !out_ready |=> state == S_FIN)
    else $error("result dropped while output stalled");

endmodule

FILE: hdl/prws_div.sv
// ----------------------------------------------------------------------------
// prws_div: shared serial divider
// Restoring division, one quotient bit per cycle, used for the running
// average, the window mean and the loss ratio in turn.
// ----------------------------------------------------------------------------
module prws_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [prws_pkg::DVD_W-1:0]   dividend,
  input  logic [prws_pkg::DVS_W-1:0]   divisor,
  output prws_pkg::div_stat_t          stat,
  output logic [prws_pkg::DVD_W-1:0]   quotient
);

  logic [prws_pkg::DVD_W-1:0]     q;
  logic [prws_pkg::DVS_W-1:0]     rem;
  logic [prws_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [prws_pkg::DVS_W:0]       rem_sh;
  logic [prws_pkg::DVS_W:0]       diff;
  logic                           ge;

  assign rem_sh = {rem, q[prws_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        rem  <= '0;
        cnt  <= prws_pkg::DIV_CNT_W'(prws_pkg::DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // The dividend shifts out at the top while quotient bits enter below.
        rem <= ge ? diff[prws_pkg::DVS_W-1:0] : rem_sh[prws_pkg::DVS_W-1:0];
        q   <= {q[prws_pkg::DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == prws_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with an exhausted count");

endmodule
